// ===== sv/twl_pkg.sv =====
// Shared types and constants for the table waveshaper with linear interpolation.
// Used by twl_lerp and table_waveshaper_lerp; depends on nothing.
package twl_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ADDR_W      = 10;
   localparam int TABLE_DEPTH = 1024;
   localparam int SIZE_W      = 11;
   localparam int POS_W       = SAMPLE_W + ADDR_W;
   localparam int REQ_DATA_W  = 48;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;

   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_WRITE  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                is_sample;
      logic                bypass;
      logic [SAMPLE_W-1:0] sample;
   } lerp_ctl_type;

endpackage

// ===== sv/twl_lerp.sv =====
// Interpolation back end: difference, scaled step and final add over three stages.
// Depends on twl_pkg.
module twl_lerp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_v,
   input  twl_pkg::lerp_ctl_type         in_ctl,
   input  logic [twl_pkg::SAMPLE_W-1:0]  in_a,
   input  logic [twl_pkg::SAMPLE_W-1:0]  in_b,
   input  logic [twl_pkg::SAMPLE_W-1:0]  in_frac,
   output logic                          out_v,
   output logic [twl_pkg::SAMPLE_W-1:0]  out_data
);

   logic                                s4_v_ff;
   twl_pkg::lerp_ctl_type               s4_ctl_ff;
   logic signed [twl_pkg::DIFF_W-1:0]   d4_in, d4_ff;
   logic [twl_pkg::SAMPLE_W-1:0]        a4_ff, frac4_ff;

   logic                                s5_v_ff;
   twl_pkg::lerp_ctl_type               s5_ctl_ff;
   logic signed [twl_pkg::PROD_W-1:0]   prod_in, prod_ff;
   logic signed [twl_pkg::DIFF_W-1:0]   d5_ff;
   logic [twl_pkg::SAMPLE_W-1:0]        a5_ff;

   logic                                out_v_ff;
   logic [twl_pkg::SAMPLE_W-1:0]        out_in, out_ff;

   logic signed [twl_pkg::DIFF_W:0]     step5;
   logic signed [twl_pkg::DIFF_W:0]     sum5;

   assign d4_in   = $signed({in_b[twl_pkg::SAMPLE_W-1], in_b})
                  - $signed({in_a[twl_pkg::SAMPLE_W-1], in_a});
   assign prod_in = d4_ff * $signed({1'b0, frac4_ff});
   assign step5   = prod_ff[twl_pkg::PROD_W-1:twl_pkg::SAMPLE_W];
   assign sum5    = $signed({{2{a5_ff[twl_pkg::SAMPLE_W-1]}}, a5_ff}) + step5;
   assign out_in  = s5_ctl_ff.bypass ? s5_ctl_ff.sample : sum5[twl_pkg::SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff  <= in_v;
         s5_v_ff  <= s4_v_ff;
         out_v_ff <= s5_v_ff && s5_ctl_ff.is_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ctl_ff <= in_ctl;
         d4_ff     <= d4_in;
         a4_ff     <= in_a;
         frac4_ff  <= in_frac;
         s5_ctl_ff <= s4_ctl_ff;
         prod_ff   <= prod_in;
         d5_ff     <= d4_ff;
         a5_ff     <= a4_ff;
         out_ff    <= out_in;
      end
   end

   assign out_v    = out_v_ff;
   assign out_data = out_ff;

   a_step_within_span: assert property (@(posedge clock) disable iff (reset)
      s5_v_ff && s5_ctl_ff.is_sample && !s5_ctl_ff.bypass |->
         ((d5_ff >= 0) ? (step5 >= 0 && step5 <= d5_ff) : (step5 <= 0 && step5 >= d5_ff)))
      else $error("interpolation step leaves the a..b span");

endmodule

// ===== sv/table_waveshaper_lerp.sv =====
// Table waveshaper with linear interpolation between neighboring transfer entries.
// Depends on twl_pkg and twl_lerp.
//
// Each item either writes one transfer-table entry (tuser high) or shapes one Q1.15
// sample (tuser low); a sample yields one result item, a write yields none. One item
// is taken every cycle: the multiply for the table position, the dual-port table read
// and the interpolation multiply each sit in their own stage, and the whole pipeline
// holds only while a finished result waits at the output. Write csr_wdata (active
// size, saturated at 1024) only while the block is idle; a size below 2 passes
// samples through unchanged. Entries must be written before a sample can reach them.
module table_waveshaper_lerp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [twl_pkg::SIZE_W-1:0]       csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] sample_in, [25:16] entry_index, [41:26] entry_value, [47:42] zero
   input  logic [twl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] req_type
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] sample_out
   output logic [twl_pkg::SAMPLE_W-1:0]     rsp_tdata
);

   logic                               en;
   logic [twl_pkg::SIZE_W-1:0]         size_in, size_ff;
   logic                               bypass;
   logic [twl_pkg::ADDR_W-1:0]         span, top_idx;

   logic                               s1_v_ff;
   twl_pkg::req_kind_type              s1_kind_ff;
   logic [twl_pkg::SAMPLE_W-1:0]       s1_sample_ff, s1_value_ff;
   logic [twl_pkg::ADDR_W-1:0]         s1_index_ff;

   logic                               s2_v_ff;
   twl_pkg::lerp_ctl_type              s2_ctl_in, s2_ctl_ff;
   logic [twl_pkg::POS_W-1:0]          pos_in, pos_ff;
   logic [twl_pkg::SAMPLE_W-1:0]       s2_value_ff;
   logic [twl_pkg::ADDR_W-1:0]         s2_index_ff;

   logic                               s3_v_ff;
   twl_pkg::lerp_ctl_type              s3_ctl_ff;
   logic [twl_pkg::SAMPLE_W-1:0]       frac3_ff;
   logic [twl_pkg::ADDR_W-1:0]         raw_idx, rd_idx, rd_idx_next;
   logic [twl_pkg::SAMPLE_W-1:0]       rd_a_ff, rd_b_ff;
   logic                               tbl_we;

   logic [twl_pkg::SAMPLE_W-1:0]       tbl_mem [twl_pkg::TABLE_DEPTH];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign size_in = (csr_wdata > twl_pkg::SIZE_W'(twl_pkg::TABLE_DEPTH))
                  ? twl_pkg::SIZE_W'(twl_pkg::TABLE_DEPTH) : csr_wdata;
   assign bypass  = size_ff < twl_pkg::SIZE_W'(2);
   assign span    = twl_pkg::ADDR_W'(size_ff - twl_pkg::SIZE_W'(1));
   assign top_idx = twl_pkg::ADDR_W'(size_ff - twl_pkg::SIZE_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_we) begin
         size_ff <= size_in;
      end
   end

   // stage 1: capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff   <= twl_pkg::req_kind_type'(req_tuser[0]);
         s1_sample_ff <= req_tdata[15:0];
         s1_index_ff  <= req_tdata[25:16];
         s1_value_ff  <= req_tdata[41:26];
      end
   end

   // stage 2: table position
   assign pos_in = twl_pkg::POS_W'(s1_sample_ff ^ twl_pkg::SIGN_FLIP)
                 * twl_pkg::POS_W'(span);

   always_comb begin
      s2_ctl_in.is_sample = (s1_kind_ff == twl_pkg::REQ_SAMPLE);
      s2_ctl_in.bypass    = bypass;
      s2_ctl_in.sample    = s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ctl_ff   <= s2_ctl_in;
         pos_ff      <= pos_in;
         s2_value_ff <= s1_value_ff;
         s2_index_ff <= s1_index_ff;
      end
   end

   // stage 3: table access
   assign raw_idx     = pos_ff[twl_pkg::POS_W-1:twl_pkg::SAMPLE_W];
   assign rd_idx      = (raw_idx > top_idx) ? top_idx : raw_idx;
   assign rd_idx_next = rd_idx + twl_pkg::ADDR_W'(1);
   assign tbl_we      = en && s2_v_ff && !s2_ctl_ff.is_sample;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[s2_index_ff] <= s2_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= tbl_mem[rd_idx];
         rd_b_ff <= tbl_mem[rd_idx_next];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ctl_ff <= s2_ctl_ff;
         frac3_ff  <= pos_ff[twl_pkg::SAMPLE_W-1:0];
      end
   end

   twl_lerp u_lerp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_v     (s3_v_ff),
      .in_ctl   (s3_ctl_ff),
      .in_a     (rd_a_ff),
      .in_b     (rd_b_ff),
      .in_frac  (frac3_ff),
      .out_v    (rsp_tvalid),
      .out_data (rsp_tdata)
   );

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && s2_ctl_ff.is_sample && !s2_ctl_ff.bypass |-> raw_idx <= top_idx)
      else $error("table position runs past the active size");

   a_stall_holds_stages: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_v_ff) && $stable(s2_v_ff) && $stable(s3_v_ff))
      else $error("pipeline stage changed while stalled");

endmodule

// ===== dv/twl_shape_checker.sv =====
// Checker for table_waveshaper_lerp: tracks the transfer table and active size,
// predicts each shaped sample and compares it with the result stream.
// Depends on twl_pkg.
`timescale 1ns / 100ps

module twl_shape_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [twl_pkg::SIZE_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [twl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [twl_pkg::SAMPLE_W-1:0]   rsp_tdata,
   output int                             mismatches,
   output int                             outstanding
);

   logic [twl_pkg::SAMPLE_W-1:0] xfer_entries [twl_pkg::TABLE_DEPTH];
   logic [twl_pkg::SIZE_W-1:0]   active_size;
   logic [twl_pkg::SAMPLE_W-1:0] shaped_q [$];

   function automatic logic [twl_pkg::SAMPLE_W-1:0] shape_sample(
      logic [twl_pkg::SAMPLE_W-1:0] s);
      int unsigned span;
      int unsigned at;
      logic [31:0] pos;
      longint      lo;
      longint      hi;
      longint      interp;
      span = (active_size > twl_pkg::TABLE_DEPTH) ? twl_pkg::TABLE_DEPTH : active_size;
      if (span < 2) return s;
      pos = {16'b0, s ^ twl_pkg::SIGN_FLIP} * (span - 1);
      at  = pos >> twl_pkg::SAMPLE_W;
      if (at > span - 2) at = span - 2;
      lo     = $signed(xfer_entries[at]);
      hi     = $signed(xfer_entries[at + 1]);
      interp = ((hi - lo) * longint'(pos[twl_pkg::SAMPLE_W-1:0])) >>> twl_pkg::SAMPLE_W;
      return twl_pkg::SAMPLE_W'(lo + interp);
   endfunction

   always @(posedge clock) begin
      logic [twl_pkg::SAMPLE_W-1:0] want;
      if (reset) begin
         active_size = '0;
         mismatches  = 0;
         shaped_q.delete();
      end else begin
         if (csr_we) active_size = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (shaped_q.size() == 0) begin
               $error("sample_out: unexpected item, expected none, got %0d",
                      $signed(rsp_tdata));
               mismatches++;
            end else begin
               want = shaped_q.pop_front();
               if (rsp_tdata !== want) begin
                  $error("sample_out mismatch: expected %0d, got %0d",
                         $signed(want), $signed(rsp_tdata));
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (twl_pkg::req_kind_type'(req_tuser[0]) == twl_pkg::REQ_WRITE)
               xfer_entries[req_tdata[25:16]] = req_tdata[41:26];
            else
               shaped_q.push_back(shape_sample(req_tdata[twl_pkg::SAMPLE_W-1:0]));
         end
      end
      outstanding = shaped_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the table_waveshaper_lerp testbench: clock, reset, table writes, samples,
// size changes and output back-pressure; twl_shape_checker does the comparison.
// Depends on twl_pkg, table_waveshaper_lerp and twl_shape_checker.
`timescale 1ns / 100ps

module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_TAIL  = 12;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           csr_we     = 1'b0;
   logic [twl_pkg::SIZE_W-1:0]     csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [twl_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]                     req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [twl_pkg::SAMPLE_W-1:0]   rsp_tdata;
   int                             mismatches;
   int                             outstanding;

   bit          written [twl_pkg::TABLE_DEPTH];
   int unsigned cur_size;
   bit          no_gaps;
   int          ready_left;
   int          quiet;

   table_waveshaper_lerp i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   twl_shape_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // output back-pressure: long open stretches, short stalls, a few long ones
   always @(negedge clock) begin
      int r;
      if (ready_left > 0) begin
         ready_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(0, 20);
         end else if (r < 92) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic push_item(twl_pkg::req_kind_type kind, logic [twl_pkg::SAMPLE_W-1:0] s,
                            logic [twl_pkg::ADDR_W-1:0] ix,
                            logic [twl_pkg::SAMPLE_W-1:0] val);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, val, ix, s};
      do @(posedge clock); while (!req_tready);
      if (kind == twl_pkg::REQ_WRITE) written[ix] = 1'b1;
      @(negedge clock);
   endtask

   task automatic write_entry(logic [twl_pkg::ADDR_W-1:0] ix,
                              logic [twl_pkg::SAMPLE_W-1:0] val);
      push_item(twl_pkg::REQ_WRITE, twl_pkg::SAMPLE_W'($urandom), ix, val);
   endtask

   // fill in the two entries the sample will read before sending it
   task automatic shape(logic [twl_pkg::SAMPLE_W-1:0] s);
      int unsigned span;
      int unsigned at;
      logic [31:0] pos;
      span = (cur_size > twl_pkg::TABLE_DEPTH) ? twl_pkg::TABLE_DEPTH : cur_size;
      if (span >= 2) begin
         pos = {16'b0, s ^ twl_pkg::SIGN_FLIP} * (span - 1);
         at  = pos >> twl_pkg::SAMPLE_W;
         if (at > span - 2) at = span - 2;
         if (!written[at])
            write_entry(twl_pkg::ADDR_W'(at), twl_pkg::SAMPLE_W'($urandom));
         if (!written[at + 1])
            write_entry(twl_pkg::ADDR_W'(at + 1), twl_pkg::SAMPLE_W'($urandom));
      end
      push_item(twl_pkg::REQ_SAMPLE, s, twl_pkg::ADDR_W'($urandom),
                twl_pkg::SAMPLE_W'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   task automatic set_size(int unsigned v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= twl_pkg::SIZE_W'(v);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_size = v;
   endtask

   initial begin
      int unsigned phase_sizes [10];
      int          r;
      phase_sizes = '{1024, 2047, 2, 3, 0, 1025, 1, 0, 1023, 37};
      phase_sizes[7] = $urandom_range(4, 1022);
      cur_size = 0;
      no_gaps  = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bypass at reset size
      shape(16'h8000);
      shape(16'h7FFF);
      shape(16'h0000);
      shape(16'hFFFF);
      write_entry(10'd0, 16'h7FFF);
      write_entry(10'd1, 16'h8000);
      write_entry(10'd1022, 16'h8000);
      write_entry(10'd1023, 16'h7FFF);
      // two entries, full-scale step down
      set_size(2);
      shape(16'h8000);
      shape(16'h7FFF);
      shape(16'h0000);
      shape(16'hC000);
      // full table: bottom and top of the table, full-scale step up
      set_size(1024);
      shape(16'h7FFF);
      shape(16'h8000);
      shape(16'h8001);
      // oversized size saturates at the table depth
      set_size(1025);
      shape(16'h7FFF);
      set_size(1);
      shape(16'h1234);

      foreach (phase_sizes[p]) begin
         set_size(phase_sizes[p]);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (65) begin
            r = $urandom_range(0, 99);
            if (r == 0) drain();
            if (r < 22)
               write_entry(twl_pkg::ADDR_W'($urandom_range(0, twl_pkg::TABLE_DEPTH - 1)),
                           twl_pkg::SAMPLE_W'($urandom));
            else if (r < 27)
               shape(r[0] ? 16'h7FFF : 16'h8000);
            else
               shape(twl_pkg::SAMPLE_W'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
